/* hdl/lz4_block_decompressor_core_defines.svh */
// Assertion macros for the LZ4 block decompressor core
`ifndef LZ4_BLOCK_DECOMPRESSOR_CORE_DEFINES_SVH
`define LZ4_BLOCK_DECOMPRESSOR_CORE_DEFINES_SVH

// check a property on every clock edge out of reset
`define LZ4D_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("lz4d assertion failed");

// check that a condition in one cycle implies another in the next
`define LZ4D_ASSERT_NEXT(lbl, ck, rn, cond, conseq) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (conseq)) \
        else $error("lz4d sequencing assertion failed");

`endif

/* hdl/lz4d_pkg.sv */
// Types, constants and codes shared by the LZ4 block decompressor
package lz4d_pkg;

    localparam int HISTORY_BYTES = 65536;
    localparam int HIST_AW       = $clog2(HISTORY_BYTES);
    localparam int LEN_W         = 17;
    localparam logic [LEN_W-1:0] LEN_MAX = 17'h1FFFF;
    localparam logic [LEN_W-1:0] CAP_MAX = 17'd65536;
    localparam logic [LEN_W-1:0] HIST_LIMIT = LEN_W'(HISTORY_BYTES);
    localparam logic [3:0] NIBBLE_ESC = 4'd15;
    localparam logic [7:0] BYTE_ESC   = 8'd255;
    localparam logic [LEN_W-1:0] MATCH_MIN = 17'd4;

    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_PULL  = 2'd1;
    localparam logic [1:0] KIND_BEGIN = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_PULL,
        OP_BEGIN,
        OP_NOP
    } op_t;

    typedef enum logic [3:0] {
        PH_TOKEN,
        PH_LITEXT,
        PH_LIT,
        PH_OFFLO,
        PH_OFFHI,
        PH_MEXT,
        PH_MATCH,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic              out_valid;
        logic [7:0]        out_byte;
        logic              accepted;
        logic              finished;
        logic              error_flag;
        logic [LEN_W-1:0]  written_total;
    } result_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       last_byte;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

endpackage

/* hdl/lz4d_ram.sv */
// Generic single-write, single-read RAM with registered read data
module lz4d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/lz4d_front.sv */
// Input acceptance, command classification and two-entry command queue
module lz4d_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  lz4d_pkg::item_t      item,
    output lz4d_pkg::head_t      head,
    input  logic                 pop
);

    lz4d_pkg::cmd_t q_reg [2];
    lz4d_pkg::cmd_t new_cmd;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           do_pop;

    always_comb
    begin
        case (item.kind)
            lz4d_pkg::KIND_PUSH:  new_cmd.op = lz4d_pkg::OP_PUSH;
            lz4d_pkg::KIND_PULL:  new_cmd.op = lz4d_pkg::OP_PULL;
            lz4d_pkg::KIND_BEGIN: new_cmd.op = lz4d_pkg::OP_BEGIN;
            default:              new_cmd.op = lz4d_pkg::OP_NOP;
        endcase
        new_cmd.data_byte = item.data_byte;
        new_cmd.last_byte = item.last_byte;
    end

    assign item_ready = (count_reg != 2'd2);
    assign push       = item_valid && item_ready;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = q_reg[0];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // shift on pop, fill the first free slot on push
    always_ff @(posedge clk)
    begin
        if (push && count_next == 2'd1)
        begin
            q_reg[0] <= new_cmd;
        end
        else if (do_pop)
        begin
            q_reg[0] <= q_reg[1];
        end
        if (push && count_next == 2'd2)
        begin
            q_reg[1] <= new_cmd;
        end
    end

endmodule

/* hdl/lz4d_back.sv */
// Sequence parser, history copy engine and result register
module lz4d_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lz4d_pkg::LEN_W-1:0]    cfg_data,
    input  lz4d_pkg::head_t               head,
    output logic                          pop,
    output logic                          result_valid,
    input  logic                          result_ready,
    output lz4d_pkg::result_t             result
);

    localparam int AW = lz4d_pkg::HIST_AW;
    localparam int LW = lz4d_pkg::LEN_W;

    lz4d_pkg::phase_t phase_reg, phase_next;
    logic [LW-1:0] lit_reg, lit_next;
    logic [LW-1:0] mlen_reg, mlen_next;
    logic [15:0]   off_reg, off_next;
    logic [3:0]    nib_reg, nib_next;
    logic [LW-1:0] wc_reg, wc_next;
    logic          ended_reg, ended_next;
    logic          failed_reg, failed_next;
    logic          wait_reg, wait_next;
    logic [LW-1:0] cap_reg;
    logic          rv_reg, rv_next;
    lz4d_pkg::result_t res_reg, res_next;

    logic          slot_free;
    logic          pull_live;
    logic          re;
    logic          we;
    logic [7:0]    wdata;
    logic [7:0]    rdata;
    logic [AW-1:0] raddr;
    logic [LW-1:0] cap_eff;
    logic [LW:0]   sat_sum;
    logic [LW-1:0] sat_len;
    logic [LW:0]   lit_need;
    logic [LW:0]   match_need;
    logic [15:0]   off_full;
    logic [LW-1:0] wc_minus;
    logic [7:0]    b;
    logic          last;
    logic          emit;
    logic [7:0]    obyte;
    logic          acc;

    lz4d_ram #(.WIDTH(8), .DEPTH(lz4d_pkg::HISTORY_BYTES)) u_hist (
        .clk   (clk),
        .we    (we),
        .waddr (wc_reg[AW-1:0]),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign b         = head.cmd.data_byte;
    assign last      = head.cmd.last_byte;
    assign slot_free = !rv_reg || result_ready;
    assign pull_live = !failed_reg && (phase_reg == lz4d_pkg::PH_MATCH) && (mlen_reg != '0);
    assign cap_eff   = (cap_reg > lz4d_pkg::CAP_MAX) ? lz4d_pkg::CAP_MAX : cap_reg;
    assign wc_minus  = wc_reg - {{(LW-16){1'b0}}, off_reg};
    assign raddr     = wc_minus[AW-1:0];
    assign off_full  = {b, off_reg[7:0]};

    always_comb
    begin
        phase_next  = phase_reg;
        lit_next    = lit_reg;
        mlen_next   = mlen_reg;
        off_next    = off_reg;
        nib_next    = nib_reg;
        wc_next     = wc_reg;
        ended_next  = ended_reg;
        failed_next = failed_reg;
        wait_next   = wait_reg;
        rv_next     = rv_reg && !result_ready;
        res_next    = res_reg;
        pop         = 1'b0;
        re          = 1'b0;
        emit        = 1'b0;
        obyte       = 8'd0;
        acc         = 1'b0;
        sat_sum     = {1'b0, lit_reg} + {{(LW-7){1'b0}}, b};
        if (phase_reg == lz4d_pkg::PH_MEXT)
        begin
            sat_sum = {1'b0, mlen_reg} + {{(LW-7){1'b0}}, b};
        end
        sat_len     = (sat_sum > {1'b0, lz4d_pkg::LEN_MAX}) ? lz4d_pkg::LEN_MAX
                                                           : sat_sum[LW-1:0];
        lit_need    = '0;
        match_need  = '0;

        if (head.valid && head.cmd.op == lz4d_pkg::OP_PULL && pull_live && !wait_reg)
        begin
            // issue the history read; the pull completes once the result slot is free
            re        = 1'b1;
            wait_next = 1'b1;
        end
        else if (head.valid && slot_free)
        begin
            pop       = 1'b1;
            wait_next = 1'b0;
            case (head.cmd.op)
                lz4d_pkg::OP_BEGIN:
                begin
                    phase_next  = lz4d_pkg::PH_TOKEN;
                    lit_next    = '0;
                    mlen_next   = '0;
                    off_next    = '0;
                    nib_next    = '0;
                    wc_next     = '0;
                    ended_next  = 1'b0;
                    failed_next = 1'b0;
                end
                lz4d_pkg::OP_PULL:
                begin
                    if (pull_live)
                    begin
                        emit      = 1'b1;
                        obyte     = rdata;
                        mlen_next = mlen_reg - {{(LW-1){1'b0}}, 1'b1};
                        if (mlen_reg == {{(LW-1){1'b0}}, 1'b1})
                        begin
                            phase_next = ended_reg ? lz4d_pkg::PH_DONE : lz4d_pkg::PH_TOKEN;
                        end
                    end
                end
                lz4d_pkg::OP_PUSH:
                begin
                    if (!failed_reg && phase_reg != lz4d_pkg::PH_MATCH
                        && phase_reg != lz4d_pkg::PH_DONE)
                    begin
                        acc = 1'b1;
                        case (phase_reg)
                            lz4d_pkg::PH_TOKEN:
                            begin
                                nib_next = b[3:0];
                                lit_next = {{(LW-4){1'b0}}, b[7:4]};
                                if (b[7:4] == lz4d_pkg::NIBBLE_ESC)
                                begin
                                    phase_next  = lz4d_pkg::PH_LITEXT;
                                    failed_next = last;
                                end
                                else
                                begin
                                    lit_need = {1'b0, wc_reg} + {{(LW-3){1'b0}}, b[7:4]};
                                    if (lit_need > {1'b0, cap_eff})
                                    begin
                                        failed_next = 1'b1;
                                    end
                                    else if (b[7:4] != 4'd0)
                                    begin
                                        phase_next  = lz4d_pkg::PH_LIT;
                                        failed_next = last;
                                    end
                                    else
                                    begin
                                        phase_next = last ? lz4d_pkg::PH_DONE
                                                          : lz4d_pkg::PH_OFFLO;
                                    end
                                end
                            end
                            lz4d_pkg::PH_LITEXT:
                            begin
                                lit_next = sat_len;
                                if (b != lz4d_pkg::BYTE_ESC)
                                begin
                                    lit_need = {1'b0, wc_reg} + {1'b0, sat_len};
                                    if (lit_need > {1'b0, cap_eff})
                                    begin
                                        failed_next = 1'b1;
                                    end
                                    else if (sat_len != '0)
                                    begin
                                        phase_next  = lz4d_pkg::PH_LIT;
                                        failed_next = last;
                                    end
                                    else
                                    begin
                                        phase_next = last ? lz4d_pkg::PH_DONE
                                                          : lz4d_pkg::PH_OFFLO;
                                    end
                                end
                                else
                                begin
                                    failed_next = last;
                                end
                            end
                            lz4d_pkg::PH_LIT:
                            begin
                                emit     = 1'b1;
                                obyte    = b;
                                lit_next = lit_reg - {{(LW-1){1'b0}}, 1'b1};
                                if (lit_reg == {{(LW-1){1'b0}}, 1'b1})
                                begin
                                    phase_next = last ? lz4d_pkg::PH_DONE
                                                      : lz4d_pkg::PH_OFFLO;
                                end
                                else
                                begin
                                    failed_next = last;
                                end
                            end
                            lz4d_pkg::PH_OFFLO:
                            begin
                                off_next    = {8'd0, b};
                                phase_next  = lz4d_pkg::PH_OFFHI;
                                failed_next = last;
                            end
                            lz4d_pkg::PH_OFFHI:
                            begin
                                off_next = off_full;
                                if (off_full == 16'd0
                                    || {{(LW-16){1'b0}}, off_full} > wc_reg
                                    || {{(LW-16){1'b0}}, off_full} > lz4d_pkg::HIST_LIMIT)
                                begin
                                    failed_next = 1'b1;
                                end
                                else
                                begin
                                    mlen_next = {{(LW-4){1'b0}}, nib_reg} + lz4d_pkg::MATCH_MIN;
                                    if (nib_reg == lz4d_pkg::NIBBLE_ESC)
                                    begin
                                        phase_next  = lz4d_pkg::PH_MEXT;
                                        failed_next = last;
                                    end
                                    else
                                    begin
                                        match_need = {1'b0, wc_reg}
                                            + {{(LW-3){1'b0}}, nib_reg}
                                            + {1'b0, lz4d_pkg::MATCH_MIN};
                                        if (match_need > {1'b0, cap_eff})
                                        begin
                                            failed_next = 1'b1;
                                        end
                                        else
                                        begin
                                            ended_next = last;
                                            phase_next = lz4d_pkg::PH_MATCH;
                                        end
                                    end
                                end
                            end
                            lz4d_pkg::PH_MEXT:
                            begin
                                mlen_next = sat_len;
                                if (b != lz4d_pkg::BYTE_ESC)
                                begin
                                    match_need = {1'b0, wc_reg} + {1'b0, sat_len};
                                    if (match_need > {1'b0, cap_eff})
                                    begin
                                        failed_next = 1'b1;
                                    end
                                    else
                                    begin
                                        ended_next = last;
                                        phase_next = lz4d_pkg::PH_MATCH;
                                    end
                                end
                                else
                                begin
                                    failed_next = last;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            if (emit)
            begin
                wc_next = wc_reg + {{(LW-1){1'b0}}, 1'b1};
            end
            rv_next                = 1'b1;
            res_next.out_valid     = emit;
            res_next.out_byte      = obyte;
            res_next.accepted      = acc;
            res_next.finished      = !failed_next && (phase_next == lz4d_pkg::PH_DONE);
            res_next.error_flag    = failed_next;
            res_next.written_total = wc_next;
        end
    end

    assign we    = emit;
    assign wdata = obyte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lz4d_pkg::PH_TOKEN;
            lit_reg    <= '0;
            mlen_reg   <= '0;
            off_reg    <= '0;
            nib_reg    <= '0;
            wc_reg     <= '0;
            ended_reg  <= 1'b0;
            failed_reg <= 1'b0;
            wait_reg   <= 1'b0;
            rv_reg     <= 1'b0;
            cap_reg    <= lz4d_pkg::CAP_MAX;
        end
        else
        begin
            phase_reg  <= phase_next;
            lit_reg    <= lit_next;
            mlen_reg   <= mlen_next;
            off_reg    <= off_next;
            nib_reg    <= nib_next;
            wc_reg     <= wc_next;
            ended_reg  <= ended_next;
            failed_reg <= failed_next;
            wait_reg   <= wait_next;
            rv_reg     <= rv_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

/* hdl/lz4_block_decompressor_core.sv */
// Top level of the LZ4 block decompressor core
// Decodes one LZ4 block from one transaction per input byte, pull or begin, and returns one
// result transaction for each. Pushes, begins and idle pulls are handled directly; a pull
// that copies a match byte first reads the history RAM (registered read port), then writes
// the byte back and delivers it. A two-entry command queue keeps input transactions
// flowing while the decoder works, and a result register holds output while it is stalled.
module lz4_block_decompressor_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lz4d_pkg::LEN_W-1:0] cfg_data,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  lz4d_pkg::item_t            item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output lz4d_pkg::result_t          result
);

    lz4d_pkg::head_t head;
    logic            pop;

    lz4d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .head       (head),
        .pop        (pop)
    );

    lz4d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* hdl/lz4d_checker.sv */
// Port-level assertions for the LZ4 block decompressor core, with bind
`include "lz4_block_decompressor_core_defines.svh"

module lz4d_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input lz4d_pkg::result_t result
);

    `LZ4D_ASSERT(a_byte_zero, clk, rst_n, !result_valid || result.out_valid || result.out_byte == 8'd0)
    `LZ4D_ASSERT(a_done_xor_err, clk, rst_n, !result_valid || !(result.finished && result.error_flag))
    `LZ4D_ASSERT(a_total_cap, clk, rst_n, !result_valid || result.written_total <= lz4d_pkg::CAP_MAX)
    `LZ4D_ASSERT_NEXT(a_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result))

endmodule

bind lz4_block_decompressor_core lz4d_checker u_lz4d_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
